[hw/rtl/nrbh_pkg.sv]
// Shared types and constants of the nearest ray-box hit search.
package nrbh_pkg;

  // Fixed point format and field widths
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int DIST_W    = 31;
  localparam int DIR_W     = 18;
  localparam int OUT_ID_W  = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  // Reciprocal and slab product widths
  localparam int INV_W   = 2 * FRAC_BITS + 1;
  localparam int IL_W    = 17;
  localparam int IH_W    = INV_W - IL_W;
  localparam int DIFF_W  = COORD_W + 2;
  localparam int MAG_W   = DIFF_W;
  localparam int PROD_W  = MAG_W + INV_W;
  localparam int SAT_BIT = DIST_W + FRAC_BITS;
  localparam int DIV_STEPS = INV_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [DIST_W-1:0] REACH_RST = DIST_W'(294912);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REACH = 3'd6;

  typedef struct packed {
    logic                       start_req;
    logic                       last;
    logic [15:0]                box_id;
    logic signed [COORD_W-1:0]  center_x;
    logic signed [COORD_W-1:0]  center_y;
    logic signed [COORD_W-1:0]  center_z;
    logic [DIST_W-1:0]          half_x;
    logic [DIST_W-1:0]          half_y;
    logic [DIST_W-1:0]          half_z;
  } in_req_t;

  typedef struct packed {
    logic                box_hit;
    logic [DIST_W-1:0]   box_distance;
    logic                best_found;
    logic [OUT_ID_W-1:0] best_id;
    logic [DIST_W-1:0]   best_distance;
    logic                done_res;
  } out_res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       setup;
    logic       zchk;
    logic       mul_lo;
    logic       mul_hi;
    logic       sum;
    logic       upd;
    logic       fin;
    logic [1:0] ax;
    logic       bnd;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic res_free;
  } sts_t;

endpackage

[hw/rtl/nrbh_recip.sv]
// Direction registers and one shared restoring divider for the per-axis reciprocals.
module nrbh_recip (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [nrbh_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [nrbh_pkg::CFG_W-1:0]            cfg_data,
  output logic [2:0][nrbh_pkg::INV_W-1:0]       inv,
  output logic [2:0]                            dir_zero,
  output logic [2:0]                            dir_neg,
  output logic                                  busy
);

  logic signed [nrbh_pkg::DIR_W-1:0] dir_r [3];
  logic [2:0][nrbh_pkg::INV_W-1:0]   inv_r;
  logic [2:0]                        pend_r, pend_nxt;
  logic                              busy_r, busy_nxt;
  logic [1:0]                        ax_r, ax_nxt;
  logic [nrbh_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [nrbh_pkg::DIR_W-1:0]        rem_r, rem_nxt;
  logic [nrbh_pkg::INV_W-1:0]        q_r, q_nxt;
  logic [nrbh_pkg::DIR_W-1:0]        dm;
  logic [nrbh_pkg::DIR_W:0]          rem_sh;
  logic                              ge;
  logic [2:0]                        wr_mask;
  logic                              last_step;

  // Write decode for the direction registers
  always_comb begin
    wr_mask = 3'b000;
    if (cfg_we) begin
      if (cfg_index == nrbh_pkg::CFG_DIR_X) wr_mask[0] = 1'b1;
      if (cfg_index == nrbh_pkg::CFG_DIR_Y) wr_mask[1] = 1'b1;
      if (cfg_index == nrbh_pkg::CFG_DIR_Z) wr_mask[2] = 1'b1;
    end
  end

  // One quotient bit a cycle; the dividend is a single one over zeros
  always_comb begin
    dm        = nrbh_pkg::DIR_W'(dir_r[ax_r][nrbh_pkg::DIR_W-1] ? -dir_r[ax_r] : dir_r[ax_r]);
    rem_sh    = {rem_r, (cnt_r == '0)};
    ge        = rem_sh >= {1'b0, dm};
    last_step = cnt_r == nrbh_pkg::DIV_CNT_W'(nrbh_pkg::DIV_STEPS - 1);
  end

  always_comb begin
    pend_nxt = pend_r;
    busy_nxt = busy_r;
    ax_nxt   = ax_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (busy_r) begin
      rem_nxt = ge ? nrbh_pkg::DIR_W'(rem_sh - {1'b0, dm}) : rem_sh[nrbh_pkg::DIR_W-1:0];
      q_nxt   = {q_r[nrbh_pkg::INV_W-2:0], ge};
      cnt_nxt = cnt_r + nrbh_pkg::DIV_CNT_W'(1);
      if (last_step) busy_nxt = 1'b0;
    end else if (pend_r != 3'b000) begin
      priority if (pend_r[0]) ax_nxt = 2'd0;
      else if (pend_r[1])     ax_nxt = 2'd1;
      else                    ax_nxt = 2'd2;
      pend_nxt[ax_nxt] = 1'b0;
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      q_nxt    = '0;
    end
    // A fresh write to the axis in flight restarts it
    if (busy_r && wr_mask[ax_r]) busy_nxt = 1'b0;
    pend_nxt = pend_nxt | wr_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'b000;
      busy_r <= 1'b0;
      ax_r   <= 2'd0;
      cnt_r  <= '0;
      for (int i = 0; i < 3; i++) dir_r[i] <= '0;
    end else begin
      pend_r <= pend_nxt;
      busy_r <= busy_nxt;
      ax_r   <= ax_nxt;
      cnt_r  <= cnt_nxt;
      for (int i = 0; i < 3; i++) begin
        if (wr_mask[i]) dir_r[i] <= cfg_data[nrbh_pkg::DIR_W-1:0];
      end
    end
  end

  // Payload of the divider
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (busy_r && last_step) inv_r[ax_r] <= q_nxt;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir_zero[i] = dir_r[i] == '0;
      dir_neg[i]  = dir_r[i][nrbh_pkg::DIR_W-1];
    end
  end

  assign inv  = inv_r;
  assign busy = busy_r | (pend_r != 3'b000);

endmodule

[hw/rtl/nrbh_ctrl.sv]
// Sequencer that walks one box through the three slabs.
module nrbh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              recip_busy,
  input  logic [2:0]        dir_zero,
  input  nrbh_pkg::sts_t    sts,
  output nrbh_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_AX, S_ZCK, S_MLO, S_MHI, S_SUM, S_UPD, S_FIN
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] ax_r, ax_nxt;
  logic       bnd_r, bnd_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE) && !recip_busy;
  assign accept   = in_valid && in_ready;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    ax_nxt    = ax_r;
    bnd_nxt   = bnd_r;
    cmd       = '0;
    cmd.ax    = ax_r;
    cmd.bnd   = bnd_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          ax_nxt    = 2'd0;
          state_nxt = S_AX;
        end
      end
      S_AX: begin
        cmd.setup = 1'b1;
        bnd_nxt   = 1'b0;
        state_nxt = dir_zero[ax_r] ? S_ZCK : S_MLO;
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        if (!bnd_r) begin
          bnd_nxt   = 1'b1;
          state_nxt = S_MLO;
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_ZCK, S_UPD: begin
        cmd.zchk = state_r == S_ZCK;
        cmd.upd  = state_r == S_UPD;
        if (ax_r == 2'd2) begin
          state_nxt = S_FIN;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = S_AX;
        end
      end
      S_FIN: begin
        if (sts.res_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ax_r    <= 2'd0;
      bnd_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ax_r    <= ax_nxt;
      bnd_r   <= bnd_nxt;
    end
  end

endmodule

[hw/rtl/nrbh_dp.sv]
// Datapath: ray registers, slab arithmetic, running nearest hit and result register.
module nrbh_dp #(
  parameter int IDW = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [nrbh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nrbh_pkg::CFG_W-1:0]       cfg_data,
  input  nrbh_pkg::in_req_t                in_req,
  input  logic [2:0][nrbh_pkg::INV_W-1:0]  inv,
  input  logic [2:0]                       dir_neg,
  input  nrbh_pkg::cmd_t                   cmd,
  output nrbh_pkg::sts_t                   sts,
  output logic                             out_valid,
  input  logic                             out_ready,
  output nrbh_pkg::out_res_t               out_res
);

  localparam int MLO_W = nrbh_pkg::MAG_W + nrbh_pkg::IL_W;
  localparam int MHI_W = nrbh_pkg::MAG_W + nrbh_pkg::IH_W;

  logic signed [nrbh_pkg::COORD_W-1:0] org_r [3];
  logic [nrbh_pkg::DIST_W-1:0]         reach_r;
  logic [nrbh_pkg::DIST_W-1:0]         best_r;
  logic [IDW-1:0]                      best_id_r;
  logic                                found_r;
  nrbh_pkg::in_req_t                   box_r;
  logic signed [nrbh_pkg::DIFF_W-1:0]  dlo_r, dhi_r;
  logic [MLO_W-1:0]                    pl_r;
  logic [MHI_W-1:0]                    ph_r;
  logic signed [nrbh_pkg::COORD_W-1:0] t_r [2];
  logic signed [nrbh_pkg::COORD_W-1:0] near_r, far_r;
  logic                                miss_r;
  nrbh_pkg::out_res_t                  res_r;
  logic                                res_valid_r;

  logic signed [nrbh_pkg::COORD_W-1:0] ctr;
  logic [nrbh_pkg::DIST_W-1:0]         hlf;
  logic signed [nrbh_pkg::DIFF_W-1:0]  lo_s, hi_s, dsel;
  logic [nrbh_pkg::MAG_W-1:0]          mag;
  logic [nrbh_pkg::INV_W-1:0]          inv_sel;
  logic [nrbh_pkg::IL_W-1:0]           mul_b;
  logic [MLO_W-1:0]                    prod;
  logic [nrbh_pkg::PROD_W-1:0]         full;
  logic [nrbh_pkg::DIST_W-1:0]         pmag;
  logic signed [nrbh_pkg::COORD_W-1:0] t_new, tmin, tmax, near_nxt, far_nxt;
  logic                                hit;
  logic signed [nrbh_pkg::COORD_W-1:0] best_s;

  // Slab bounds relative to the origin
  always_comb begin
    unique case (cmd.ax)
      2'd0:    begin ctr = box_r.center_x; hlf = box_r.half_x; end
      2'd1:    begin ctr = box_r.center_y; hlf = box_r.half_y; end
      default: begin ctr = box_r.center_z; hlf = box_r.half_z; end
    endcase
    lo_s = nrbh_pkg::DIFF_W'(ctr) - $signed({3'b000, hlf})
         - nrbh_pkg::DIFF_W'(org_r[cmd.ax]);
    hi_s = nrbh_pkg::DIFF_W'(ctr) + $signed({3'b000, hlf})
         - nrbh_pkg::DIFF_W'(org_r[cmd.ax]);
  end

  // Magnitude times reciprocal on one shared multiplier, low then high part
  always_comb begin
    dsel    = cmd.bnd ? dhi_r : dlo_r;
    mag     = nrbh_pkg::MAG_W'(dsel[nrbh_pkg::DIFF_W-1] ? -dsel : dsel);
    inv_sel = inv[cmd.ax];
    mul_b   = cmd.mul_hi ? nrbh_pkg::IL_W'(inv_sel[nrbh_pkg::INV_W-1:nrbh_pkg::IL_W])
                         : inv_sel[nrbh_pkg::IL_W-1:0];
    prod    = MLO_W'(mag) * MLO_W'(mul_b);
    full    = nrbh_pkg::PROD_W'(pl_r) + (nrbh_pkg::PROD_W'(ph_r) << nrbh_pkg::IL_W);
    pmag    = (|full[nrbh_pkg::PROD_W-1:nrbh_pkg::SAT_BIT]) ? '1
            : full[nrbh_pkg::SAT_BIT-1:nrbh_pkg::FRAC_BITS];
    t_new   = (dsel[nrbh_pkg::DIFF_W-1] ^ dir_neg[cmd.ax]) ? -$signed({1'b0, pmag})
                                                           : $signed({1'b0, pmag});
  end

  // Interval clipping
  always_comb begin
    tmin     = (t_r[0] > t_r[1]) ? t_r[1] : t_r[0];
    tmax     = (t_r[0] > t_r[1]) ? t_r[0] : t_r[1];
    near_nxt = (tmin > near_r) ? tmin : near_r;
    far_nxt  = (tmax < far_r) ? tmax : far_r;
    best_s   = $signed({1'b0, best_r});
    hit      = !miss_r && (near_r <= best_s);
  end

  assign sts.res_free = !res_valid_r || out_ready;

  // Ray registers and running nearest hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) org_r[i] <= '0;
      reach_r     <= nrbh_pkg::REACH_RST;
      best_r      <= '0;
      best_id_r   <= '0;
      found_r     <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == nrbh_pkg::CFG_ORG_X) org_r[0] <= cfg_data;
        if (cfg_index == nrbh_pkg::CFG_ORG_Y) org_r[1] <= cfg_data;
        if (cfg_index == nrbh_pkg::CFG_ORG_Z) org_r[2] <= cfg_data;
        if (cfg_index == nrbh_pkg::CFG_REACH) reach_r  <= cfg_data[nrbh_pkg::DIST_W-1:0];
      end
      if (cmd.load && in_req.start_req) begin
        best_r    <= reach_r;
        best_id_r <= '0;
        found_r   <= 1'b0;
      end
      if (cmd.fin && hit) begin
        best_r    <= near_r[nrbh_pkg::DIST_W-1:0];
        best_id_r <= box_r.box_id[IDW-1:0];
        found_r   <= 1'b1;
      end
      if (cmd.fin)            res_valid_r <= 1'b1;
      else if (out_ready)     res_valid_r <= 1'b0;
    end
  end

  // Per-box working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      box_r  <= in_req;
      near_r <= '0;
      far_r  <= $signed({1'b0, in_req.start_req ? reach_r : best_r});
      miss_r <= 1'b0;
    end
    if (cmd.setup) begin
      dlo_r <= lo_s;
      dhi_r <= hi_s;
    end
    if (cmd.zchk && (dlo_r > 0 || dhi_r < 0)) miss_r <= 1'b1;
    if (cmd.mul_lo) pl_r <= prod;
    if (cmd.mul_hi) ph_r <= MHI_W'(prod);
    if (cmd.sum)    t_r[cmd.bnd] <= t_new;
    if (cmd.upd) begin
      near_r <= near_nxt;
      far_r  <= far_nxt;
      if (near_nxt > far_nxt) miss_r <= 1'b1;
    end
    if (cmd.fin) begin
      res_r.box_hit       <= hit;
      res_r.box_distance  <= hit ? near_r[nrbh_pkg::DIST_W-1:0] : '0;
      res_r.best_found    <= found_r | hit;
      res_r.best_id       <= hit ? nrbh_pkg::OUT_ID_W'(box_r.box_id[IDW-1:0])
                                 : nrbh_pkg::OUT_ID_W'(best_id_r);
      res_r.best_distance <= hit ? near_r[nrbh_pkg::DIST_W-1:0] : best_r;
      res_r.done_res      <= box_r.last;
    end
  end

  assign out_valid = res_valid_r;
  assign out_res   = res_r;

endmodule

[hw/rtl/nearest_ray_box_hit.sv]
// Top level of the nearest ray-box hit search.
//
// Usage: write the ray origin, direction and reach on the cfg_ port, then send
// boxes on the in_ channel; a box with start_req set opens a query and resets
// the best distance to the reach. Each box gives one result request on the out_
// channel carrying its own hit and distance plus the running nearest hit;
// done_res echoes last.
// Sequence: after the accept, each axis runs a setup state, then for a non-zero
// direction component low product, high product and sum per bound and an update,
// or for a zero one a zero check; a finish state then waits for a free result
// register, and only then is the next box taken. The single shared 34x17
// multiplier forms two partial products per slab bound of a non-zero direction axis.
// Each direction write queues a 33-step reciprocal division in a shared
// restoring divider; in_ready stays low until all pending divisions finish.
// Reset loads the register defaults (reach 4.5, all else zero) and clears the
// running best. When the receiver stalls, the result register holds; one more
// box is processed and then waits for the register to empty.
module nearest_ray_box_hit #(
  parameter int ID_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [nrbh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nrbh_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  nrbh_pkg::in_req_t                in_req,
  output logic                             out_valid,
  input  logic                             out_ready,
  output nrbh_pkg::out_res_t               out_res
);

  localparam int IDW = (ID_BITS < nrbh_pkg::OUT_ID_W) ? ID_BITS : nrbh_pkg::OUT_ID_W;

  logic [2:0][nrbh_pkg::INV_W-1:0] inv;
  logic [2:0]                      dir_zero;
  logic [2:0]                      dir_neg;
  logic                            recip_busy;
  nrbh_pkg::cmd_t                  cmd;
  nrbh_pkg::sts_t                  sts;

  nrbh_recip u_recip (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .inv       (inv),
    .dir_zero  (dir_zero),
    .dir_neg   (dir_neg),
    .busy      (recip_busy)
  );

  nrbh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .recip_busy (recip_busy),
    .dir_zero   (dir_zero),
    .sts        (sts),
    .cmd        (cmd)
  );

  nrbh_dp #(
    .IDW (IDW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_req    (in_req),
    .inv       (inv),
    .dir_neg   (dir_neg),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // No box taken while a reciprocal is stale
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    recip_busy |-> !in_ready)
    else $error("box accepted during reciprocal update");

  // A box occupies the sequencer for at least the next cycle
  a_one_box: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second box accepted while one is in flight");

  // Reset empties the result register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule
